// ----- rtl/assert_macros.svh -----
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define MQM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("message queue manager assertion failed");

// next-cycle implication, checked out of reset
`define MQM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("message queue manager assertion failed");

`endif

// ----- rtl/mqm_pkg.sv -----
// shared types, codes and defaults of the message queue manager
package mqm_pkg;

    // default sizes
    localparam int NUM_QUEUES_DEF  = 8;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int WAITERS_DEF     = 8;

    // field widths
    localparam int ACT_W  = 3;
    localparam int QIDX_W = 4;
    localparam int CAP_W  = 5;
    localparam int DATA_W = 32;
    localparam int TID_W  = 4;
    localparam int MODE_W = 2;
    localparam int STAT_W = 3;
    localparam int CNT_W  = 5;

    // action codes
    localparam logic [ACT_W-1:0] ACT_CREATE  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_DELETE  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_SEND    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_RECEIVE = 3'd3;
    localparam logic [ACT_W-1:0] ACT_PEEK    = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_ERR     = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd3;
    localparam logic [STAT_W-1:0] ST_TIMEOUT = 3'd4;

    // wait modes
    localparam logic [MODE_W-1:0] MODE_NO_WAIT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FOREVER = 2'd2;

    // commands from the controller
    typedef struct packed {
        logic load_in;
        logic exec;
        logic pop;
        logic emit;
    } t_mqm_cmd;

    // status back to the controller
    typedef struct packed {
        logic walk;
        logic last;
        logic out_free;
    } t_mqm_stat;

endpackage

// ----- rtl/mqm_ram.sv -----
// generic single write port ram with registered read
module mqm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/mqm_ctrl.sv -----
// controller state machine of the message queue manager
module mqm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  mqm_pkg::t_mqm_stat i_stat,
    output mqm_pkg::t_mqm_cmd  o_cmd
);
    import mqm_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;
    localparam logic [1:0] S_DPOP = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_stat.walk ? S_DPOP : S_EMIT;
            end
            S_DPOP: begin
                o_cmd.pop = 1'b1;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_stat.last ? S_IDLE : S_DPOP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE) || !i_rst_n;
endmodule

// ----- rtl/mqm_dp.sv -----
// datapath: queue bookkeeping, storage, wait lists and result register
module mqm_dp #(
    parameter int NQ = mqm_pkg::NUM_QUEUES_DEF,
    parameter int QD = mqm_pkg::QUEUE_DEPTH_DEF,
    parameter int WL = mqm_pkg::WAITERS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mqm_pkg::t_mqm_cmd           i_cmd,
    output mqm_pkg::t_mqm_stat          o_stat,
    input  logic [mqm_pkg::ACT_W-1:0]   i_action,
    input  logic [mqm_pkg::QIDX_W-1:0]  i_queue_index,
    input  logic [mqm_pkg::CAP_W-1:0]   i_capacity,
    input  logic [mqm_pkg::DATA_W-1:0]  i_data_word,
    input  logic [mqm_pkg::TID_W-1:0]   i_task_id,
    input  logic                        i_task_known,
    input  logic [mqm_pkg::MODE_W-1:0]  i_wait_mode,
    input  logic                        i_stall,
    output logic                        o_valid,
    output logic [mqm_pkg::STAT_W-1:0]  o_status,
    output logic [mqm_pkg::DATA_W-1:0]  o_data_out,
    output logic [mqm_pkg::CNT_W-1:0]   o_item_count,
    output logic [mqm_pkg::CNT_W-1:0]   o_free_space,
    output logic                        o_caller_blocked,
    output logic                        o_woken_valid,
    output logic [mqm_pkg::TID_W-1:0]   o_woken_task,
    output logic                        o_woken_side,
    output logic                        o_last
);
    import mqm_pkg::*;

    localparam int QIW = (NQ > 1) ? $clog2(NQ) : 1;
    localparam int PW  = (QD > 1) ? $clog2(QD) : 1;
    localparam int CW  = $clog2(QD + 1);
    localparam int LW  = (WL > 1) ? $clog2(WL) : 1;
    localparam int LCW = $clog2(WL + 1);
    localparam int SAW = (NQ * QD > 1) ? $clog2(NQ * QD) : 1;
    localparam int WAW = (NQ * WL > 1) ? $clog2(NQ * WL) : 1;
    localparam logic [QIDX_W:0] NQ_V = (QIDX_W + 1)'(NQ);
    localparam logic [CAP_W-1:0] QD_V = CAP_W'(QD);
    localparam logic [LCW-1:0]  WL_V = LCW'(WL);

    // captured request
    logic [ACT_W-1:0]  r_act;
    logic [QIDX_W-1:0] r_q;
    logic [CAP_W-1:0]  r_cap_in;
    logic [DATA_W-1:0] r_word;
    logic [TID_W-1:0]  r_tid;
    logic              r_known;
    logic [MODE_W-1:0] r_mode;

    // per-queue bookkeeping
    logic          r_active [NQ];
    logic [CW-1:0] r_qcap   [NQ];
    logic [PW-1:0] r_rp     [NQ];
    logic [PW-1:0] r_wp     [NQ];
    logic [CW-1:0] r_cnt    [NQ];
    logic [LW-1:0] r_shead  [NQ];
    logic [LCW-1:0] r_scnt  [NQ];
    logic [LW-1:0] r_rhead  [NQ];
    logic [LCW-1:0] r_rcnt  [NQ];

    // latched result fields
    logic [STAT_W-1:0] r_res_status;
    logic              r_res_blocked;
    logic              r_res_wv;
    logic              r_res_ws;
    logic              r_res_data_en;
    logic              r_res_last;

    // output register
    logic              r_ov;
    logic [STAT_W-1:0] r_o_status;
    logic [DATA_W-1:0] r_o_data;
    logic [CNT_W-1:0]  r_o_cnt;
    logic [CNT_W-1:0]  r_o_space;
    logic              r_o_blocked;
    logic              r_o_wv;
    logic [TID_W-1:0]  r_o_wt;
    logic              r_o_ws;
    logic              r_o_last;

    logic           qok;
    logic [QIW-1:0] qi;
    logic           c_active;
    logic [CW-1:0]  c_cap;
    logic [PW-1:0]  c_rp;
    logic [PW-1:0]  c_wp;
    logic [CW-1:0]  c_cnt;
    logic [LW-1:0]  c_shead;
    logic [LCW-1:0] c_scnt;
    logic [LW-1:0]  c_rhead;
    logic [LCW-1:0] c_rcnt;

    logic [CW-1:0]  wp_inc;
    logic [CW-1:0]  rp_inc;
    logic [PW-1:0]  np_w;
    logic [PW-1:0]  np_r;
    logic [LW:0]    s_sum;
    logic [LW:0]    r_sum;
    logic [LW-1:0]  s_slot;
    logic [LW-1:0]  r_slot;
    logic [LW:0]    s_hinc;
    logic [LW:0]    r_hinc;
    logic [LW-1:0]  s_hnext;
    logic [LW-1:0]  r_hnext;

    logic              e_walk;
    logic [STAT_W-1:0] e_status;
    logic              e_blocked;
    logic              e_wv;
    logic              e_ws;
    logic              e_data_en;
    logic              do_create;
    logic              do_deact;
    logic              do_send;
    logic              do_recv;
    logic              st_re;
    logic              push_s;
    logic              push_r;
    logic              pop_s;
    logic              pop_r;
    logic              p_side;
    logic              p_last;

    logic [SAW-1:0]    st_base;
    logic [SAW-1:0]    st_waddr;
    logic [SAW-1:0]    st_raddr;
    logic [WAW-1:0]    wl_base;
    logic [DATA_W-1:0] st_rdata;
    logic [TID_W-1:0]  s_rdata;
    logic [TID_W-1:0]  r_rdata;

    logic [CW-1:0]     out_space;

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_act    <= i_action;
            r_q      <= i_queue_index;
            r_cap_in <= i_capacity;
            r_word   <= i_data_word;
            r_tid    <= i_task_id;
            r_known  <= i_task_known;
            r_mode   <= i_wait_mode;
        end
    end

    // addressed queue
    assign qok      = {1'b0, r_q} < NQ_V;
    assign qi       = r_q[QIW-1:0];
    assign c_active = r_active[qi];
    assign c_cap    = r_qcap[qi];
    assign c_rp     = r_rp[qi];
    assign c_wp     = r_wp[qi];
    assign c_cnt    = r_cnt[qi];
    assign c_shead  = r_shead[qi];
    assign c_scnt   = r_scnt[qi];
    assign c_rhead  = r_rhead[qi];
    assign c_rcnt   = r_rcnt[qi];

    // ring pointer advance, wrapping at the capacity
    assign wp_inc = CW'(c_wp) + 1'b1;
    assign rp_inc = CW'(c_rp) + 1'b1;
    assign np_w   = (wp_inc == c_cap) ? '0 : wp_inc[PW-1:0];
    assign np_r   = (rp_inc == c_cap) ? '0 : rp_inc[PW-1:0];

    // wait list tail slots and head advance
    assign s_sum   = (LW + 1)'(c_shead) + (LW + 1)'(c_scnt);
    assign r_sum   = (LW + 1)'(c_rhead) + (LW + 1)'(c_rcnt);
    assign s_slot  = (s_sum >= (LW + 1)'(WL)) ? LW'(s_sum - (LW + 1)'(WL)) : s_sum[LW-1:0];
    assign r_slot  = (r_sum >= (LW + 1)'(WL)) ? LW'(r_sum - (LW + 1)'(WL)) : r_sum[LW-1:0];
    assign s_hinc  = (LW + 1)'(c_shead) + 1'b1;
    assign r_hinc  = (LW + 1)'(c_rhead) + 1'b1;
    assign s_hnext = (s_hinc == (LW + 1)'(WL)) ? '0 : s_hinc[LW-1:0];
    assign r_hnext = (r_hinc == (LW + 1)'(WL)) ? '0 : r_hinc[LW-1:0];

    // delete walk: senders first, then receivers
    assign p_side = c_scnt != '0;
    assign p_last = p_side ? ((c_scnt == LCW'(1)) && (c_rcnt == '0)) : (c_rcnt == LCW'(1));

    // action decode
    always_comb begin
        e_walk    = 1'b0;
        e_status  = ST_ERR;
        e_blocked = 1'b0;
        e_wv      = 1'b0;
        e_ws      = 1'b0;
        e_data_en = 1'b0;
        do_create = 1'b0;
        do_deact  = 1'b0;
        do_send   = 1'b0;
        do_recv   = 1'b0;
        st_re     = 1'b0;
        push_s    = 1'b0;
        push_r    = 1'b0;
        pop_s     = 1'b0;
        pop_r     = 1'b0;
        if (i_cmd.exec && qok) begin
            case (r_act)
                ACT_CREATE: begin
                    if (r_cap_in != '0 && r_cap_in <= QD_V && !c_active) begin
                        do_create = 1'b1;
                        e_status  = ST_OK;
                    end
                end
                ACT_DELETE: begin
                    if (c_active) begin
                        e_status = ST_OK;
                        if (c_scnt != '0 || c_rcnt != '0) begin
                            e_walk = 1'b1;
                        end else begin
                            do_deact = 1'b1;
                        end
                    end
                end
                ACT_SEND: begin
                    if (c_active) begin
                        if (c_cnt >= c_cap) begin
                            e_status = ST_FULL;
                            if (r_mode != MODE_NO_WAIT && r_known) begin
                                push_s    = c_scnt < WL_V;
                                e_blocked = push_s;
                                if (r_mode != MODE_FOREVER) begin
                                    e_status = ST_TIMEOUT;
                                end
                            end
                        end else begin
                            do_send  = 1'b1;
                            e_status = ST_OK;
                            if (c_rcnt != '0) begin
                                pop_r = 1'b1;
                                e_wv  = 1'b1;
                            end
                        end
                    end
                end
                ACT_RECEIVE: begin
                    if (c_active) begin
                        if (c_cnt == '0) begin
                            e_status = ST_EMPTY;
                            if (r_mode != MODE_NO_WAIT && r_known) begin
                                push_r    = c_rcnt < WL_V;
                                e_blocked = push_r;
                                if (r_mode != MODE_FOREVER) begin
                                    e_status = ST_TIMEOUT;
                                end
                            end
                        end else begin
                            do_recv   = 1'b1;
                            st_re     = 1'b1;
                            e_data_en = 1'b1;
                            e_status  = ST_OK;
                            if (c_scnt != '0) begin
                                pop_s = 1'b1;
                                e_wv  = 1'b1;
                                e_ws  = 1'b1;
                            end
                        end
                    end
                end
                ACT_PEEK: begin
                    if (!c_active || c_cnt == '0) begin
                        e_status = ST_EMPTY;
                    end else begin
                        st_re     = 1'b1;
                        e_data_en = 1'b1;
                        e_status  = ST_OK;
                    end
                end
                default: begin
                    e_status = ST_ERR;
                end
            endcase
        end
        if (i_cmd.pop) begin
            pop_s = p_side;
            pop_r = !p_side;
        end
    end

    // queue bookkeeping update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NQ; i++) begin
                r_active[i] <= 1'b0;
                r_qcap[i]   <= '0;
                r_rp[i]     <= '0;
                r_wp[i]     <= '0;
                r_cnt[i]    <= '0;
                r_shead[i]  <= '0;
                r_scnt[i]   <= '0;
                r_rhead[i]  <= '0;
                r_rcnt[i]   <= '0;
            end
        end else begin
            if (do_create) begin
                r_active[qi] <= 1'b1;
                r_qcap[qi]   <= CW'(r_cap_in);
                r_rp[qi]     <= '0;
                r_wp[qi]     <= '0;
                r_cnt[qi]    <= '0;
                r_shead[qi]  <= '0;
                r_scnt[qi]   <= '0;
                r_rhead[qi]  <= '0;
                r_rcnt[qi]   <= '0;
            end
            if (do_deact || (i_cmd.pop && p_last)) begin
                r_active[qi] <= 1'b0;
            end
            if (do_send) begin
                r_wp[qi]  <= np_w;
                r_cnt[qi] <= c_cnt + 1'b1;
            end
            if (do_recv) begin
                r_rp[qi]  <= np_r;
                r_cnt[qi] <= c_cnt - 1'b1;
            end
            if (push_s) begin
                r_scnt[qi] <= c_scnt + 1'b1;
            end
            if (push_r) begin
                r_rcnt[qi] <= c_rcnt + 1'b1;
            end
            if (pop_s) begin
                r_shead[qi] <= s_hnext;
                r_scnt[qi]  <= c_scnt - 1'b1;
            end
            if (pop_r) begin
                r_rhead[qi] <= r_hnext;
                r_rcnt[qi]  <= c_rcnt - 1'b1;
            end
        end
    end

    // result fields for the pending request
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_res_status  <= e_status;
            r_res_blocked <= e_blocked;
            r_res_wv      <= e_wv;
            r_res_ws      <= e_ws;
            r_res_data_en <= e_data_en;
            r_res_last    <= 1'b1;
        end else if (i_cmd.pop) begin
            r_res_status  <= ST_OK;
            r_res_blocked <= 1'b0;
            r_res_wv      <= 1'b1;
            r_res_ws      <= p_side;
            r_res_data_en <= 1'b0;
            r_res_last    <= p_last;
        end
    end

    // memory addresses
    assign st_base  = SAW'(qi) * SAW'(QD);
    assign st_waddr = st_base + SAW'(c_wp);
    assign st_raddr = st_base + SAW'(c_rp);
    assign wl_base  = WAW'(qi) * WAW'(WL);

    // word storage
    mqm_ram #(.WIDTH(DATA_W), .DEPTH(NQ * QD), .AW(SAW)) u_store (
        .i_clk   (i_clk),
        .i_we    (do_send),
        .i_waddr (st_waddr),
        .i_wdata (r_word),
        .i_re    (st_re),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    // sender wait lists
    mqm_ram #(.WIDTH(TID_W), .DEPTH(NQ * WL), .AW(WAW)) u_slist (
        .i_clk   (i_clk),
        .i_we    (push_s),
        .i_waddr (wl_base + WAW'(s_slot)),
        .i_wdata (r_tid),
        .i_re    (pop_s),
        .i_raddr (wl_base + WAW'(c_shead)),
        .o_rdata (s_rdata)
    );

    // receiver wait lists
    mqm_ram #(.WIDTH(TID_W), .DEPTH(NQ * WL), .AW(WAW)) u_rlist (
        .i_clk   (i_clk),
        .i_we    (push_r),
        .i_waddr (wl_base + WAW'(r_slot)),
        .i_wdata (r_tid),
        .i_re    (pop_r),
        .i_raddr (wl_base + WAW'(c_rhead)),
        .o_rdata (r_rdata)
    );

    // counts after the step
    assign out_space = (c_cap >= c_cnt) ? (c_cap - c_cnt) : '0;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ov <= 1'b1;
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_status  <= r_res_status;
            r_o_data    <= r_res_data_en ? st_rdata : '0;
            r_o_cnt     <= qok ? CNT_W'(c_cnt) : '0;
            r_o_space   <= qok ? CNT_W'(out_space) : '0;
            r_o_blocked <= r_res_blocked;
            r_o_wv      <= r_res_wv;
            r_o_wt      <= r_res_wv ? (r_res_ws ? s_rdata : r_rdata) : '0;
            r_o_ws      <= r_res_wv & r_res_ws;
            r_o_last    <= r_res_last;
        end
    end

    assign o_stat.walk     = e_walk;
    assign o_stat.last     = r_res_last;
    assign o_stat.out_free = !r_ov || !i_stall;

    assign o_valid          = r_ov;
    assign o_status         = r_o_status;
    assign o_data_out       = r_o_data;
    assign o_item_count     = r_o_cnt;
    assign o_free_space     = r_o_space;
    assign o_caller_blocked = r_o_blocked;
    assign o_woken_valid    = r_o_wv;
    assign o_woken_task     = r_o_wt;
    assign o_woken_side     = r_o_ws;
    assign o_last           = r_o_last;
endmodule

// ----- rtl/message_queue_manager.sv -----
// message queue manager: a new request is taken only after the previous one has loaded its last result
// a request is taken, executed against the bookkeeping and memories, then loaded to the output
// a delete that wakes k tasks gives k results, each by a wait-list ram read, then output
// results wait in an output register; a new request is taken while one waits there
// synchronous active-low reset clears all queue, pointer and wait-list bookkeeping at once
// word storage and wait-list memories are not cleared; nothing reads them before a write
`include "assert_macros.svh"
module message_queue_manager #(
    parameter int NUM_QUEUES       = mqm_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH      = mqm_pkg::QUEUE_DEPTH_DEF,
    parameter int WAITERS_PER_LIST = mqm_pkg::WAITERS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [mqm_pkg::ACT_W-1:0]   i_action,
    input  logic [mqm_pkg::QIDX_W-1:0]  i_queue_index,
    input  logic [mqm_pkg::CAP_W-1:0]   i_capacity,
    input  logic [mqm_pkg::DATA_W-1:0]  i_data_word,
    input  logic [mqm_pkg::TID_W-1:0]   i_task_id,
    input  logic                        i_task_known,
    input  logic [mqm_pkg::MODE_W-1:0]  i_wait_mode,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [mqm_pkg::STAT_W-1:0]  o_status,
    output logic [mqm_pkg::DATA_W-1:0]  o_data_out,
    output logic [mqm_pkg::CNT_W-1:0]   o_item_count,
    output logic [mqm_pkg::CNT_W-1:0]   o_free_space,
    output logic                        o_caller_blocked,
    output logic                        o_woken_valid,
    output logic [mqm_pkg::TID_W-1:0]   o_woken_task,
    output logic                        o_woken_side,
    output logic                        o_last
);
    import mqm_pkg::*;

    t_mqm_cmd  cmd;
    t_mqm_stat stat;

    // sequencing
    mqm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // queue state and memories
    mqm_dp #(
        .NQ (NUM_QUEUES),
        .QD (QUEUE_DEPTH),
        .WL (WAITERS_PER_LIST)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_action         (i_action),
        .i_queue_index    (i_queue_index),
        .i_capacity       (i_capacity),
        .i_data_word      (i_data_word),
        .i_task_id        (i_task_id),
        .i_task_known     (i_task_known),
        .i_wait_mode      (i_wait_mode),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_data_out       (o_data_out),
        .o_item_count     (o_item_count),
        .o_free_space     (o_free_space),
        .o_caller_blocked (o_caller_blocked),
        .o_woken_valid    (o_woken_valid),
        .o_woken_task     (o_woken_task),
        .o_woken_side     (o_woken_side),
        .o_last           (o_last)
    );

    // a taken request keeps the input side closed while it executes
    `MQM_ASSERT_NEXT(a_busy_after_request, i_valid && !o_stall, o_stall)
    // a loaded result is presented next cycle
    `MQM_ASSERT_NEXT(a_emit_shows, cmd.emit, o_valid)
    // a blocked caller never comes with a woken task
    `MQM_ASSERT_IMPL(a_block_no_wake, o_valid && o_caller_blocked, !o_woken_valid)
    // a woken task is always reported with success
    `MQM_ASSERT_IMPL(a_wake_ok, o_valid && o_woken_valid, o_status == ST_OK)
endmodule

// ----- tb/sv/testbench.sv -----
// testbench for message_queue_manager: directed and random requests checked against a predictor
`timescale 1ns / 1ps
module testbench;
    import mqm_pkg::*;

    localparam int NQ = NUM_QUEUES_DEF;
    localparam int QD = QUEUE_DEPTH_DEF;
    localparam int NW = WAITERS_DEF;
    localparam int IDLE_LIMIT = 2000;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [QIDX_W-1:0] qidx;
        logic [CAP_W-1:0]  cap;
        logic [DATA_W-1:0] word;
        logic [TID_W-1:0]  tid;
        logic              known;
        logic [MODE_W-1:0] mode;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] data;
        logic [CNT_W-1:0]  cnt;
        logic [CNT_W-1:0]  space;
        logic              blocked;
        logic              wv;
        logic [TID_W-1:0]  wt;
        logic              ws;
        logic              last;
    } res_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [ACT_W-1:0]  i_action = '0;
    logic [QIDX_W-1:0] i_queue_index = '0;
    logic [CAP_W-1:0]  i_capacity = '0;
    logic [DATA_W-1:0] i_data_word = '0;
    logic [TID_W-1:0]  i_task_id = '0;
    logic i_task_known = 1'b0;
    logic [MODE_W-1:0] i_wait_mode = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [STAT_W-1:0] o_status;
    logic [DATA_W-1:0] o_data_out;
    logic [CNT_W-1:0]  o_item_count;
    logic [CNT_W-1:0]  o_free_space;
    logic o_caller_blocked, o_woken_valid, o_woken_side, o_last;
    logic [TID_W-1:0] o_woken_task;

    message_queue_manager dut (.*);

    // clock
    always #1 i_clk = ~i_clk;

    // predictor state
    bit              q_active [NQ];
    logic [CNT_W-1:0] q_cap [NQ];
    logic [CNT_W-1:0] q_cnt [NQ];
    logic [3:0]      rd_ptr [NQ];
    logic [3:0]      wr_ptr [NQ];
    logic [DATA_W-1:0] words [NQ][QD];
    logic [TID_W-1:0] snd_ids [NQ][NW];
    logic [TID_W-1:0] rcv_ids [NQ][NW];
    int              snd_n [NQ];
    int              rcv_n [NQ];

    res_t expected_results [$];
    bit   failed = 1'b0;
    bit   no_idle = 1'b0;
    int   out_stall_left = 0;
    int   idle_cycles = 0;

    function automatic req_t mk(logic [2:0] a, logic [3:0] q, logic [4:0] c, logic [31:0] w,
                                logic [3:0] t, logic k, logic [1:0] m);
        req_t r;
        r.action = a; r.qidx = q; r.cap = c; r.word = w;
        r.tid = t; r.known = k; r.mode = m;
        return r;
    endfunction

    // pop oldest waiter of a sender (side 1) or receiver (side 0) list
    function automatic logic [3:0] pop_waiter(int q, bit side);
        logic [3:0] id;
        if (side) begin
            id = snd_ids[q][0];
            for (int i = 0; i + 1 < snd_n[q]; i++) snd_ids[q][i] = snd_ids[q][i+1];
            snd_n[q]--;
        end else begin
            id = rcv_ids[q][0];
            for (int i = 0; i + 1 < rcv_n[q]; i++) rcv_ids[q][i] = rcv_ids[q][i+1];
            rcv_n[q]--;
        end
        return id;
    endfunction

    // work out the results of one accepted request and update the queue state
    task automatic predict_queue_op(input req_t r);
        res_t e;
        int q;
        int nwk;
        logic [3:0] wk_id [2*NW];
        bit wk_side [2*NW];
        bit full_or_empty;
        e = '0;
        e.status = ST_ERR;
        e.last = 1'b1;
        nwk = 0;
        q = r.qidx;
        if (q >= NQ) begin
            expected_results.push_back(e);
            return;
        end
        case (r.action)
            ACT_CREATE: begin
                if (r.cap != 0 && r.cap <= QD && !q_active[q]) begin
                    q_active[q] = 1; q_cap[q] = r.cap;
                    rd_ptr[q] = 0; wr_ptr[q] = 0; q_cnt[q] = 0;
                    snd_n[q] = 0; rcv_n[q] = 0;
                    e.status = ST_OK;
                end
            end
            ACT_DELETE: begin
                if (q_active[q]) begin
                    while (snd_n[q] > 0) begin
                        wk_id[nwk] = pop_waiter(q, 1'b1); wk_side[nwk] = 1; nwk++;
                    end
                    while (rcv_n[q] > 0) begin
                        wk_id[nwk] = pop_waiter(q, 1'b0); wk_side[nwk] = 0; nwk++;
                    end
                    q_active[q] = 0;
                    e.status = ST_OK;
                end
            end
            ACT_SEND, ACT_RECEIVE: begin
                if (q_active[q]) begin
                    full_or_empty = (r.action == ACT_SEND) ? (q_cnt[q] >= q_cap[q])
                                                           : (q_cnt[q] == 0);
                    if (full_or_empty) begin
                        e.status = (r.action == ACT_SEND) ? ST_FULL : ST_EMPTY;
                        if (r.mode != MODE_NO_WAIT && r.known) begin
                            if (r.action == ACT_SEND && snd_n[q] < NW) begin
                                snd_ids[q][snd_n[q]] = r.tid; snd_n[q]++; e.blocked = 1;
                            end else if (r.action == ACT_RECEIVE && rcv_n[q] < NW) begin
                                rcv_ids[q][rcv_n[q]] = r.tid; rcv_n[q]++; e.blocked = 1;
                            end
                            if (r.mode != MODE_FOREVER) e.status = ST_TIMEOUT;
                        end
                    end else if (r.action == ACT_SEND) begin
                        words[q][wr_ptr[q]] = r.word;
                        wr_ptr[q] = 4'((int'(wr_ptr[q]) + 1) % int'(q_cap[q]));
                        q_cnt[q]++;
                        if (rcv_n[q] > 0) begin
                            e.wv = 1; e.ws = 0; e.wt = pop_waiter(q, 1'b0);
                        end
                        e.status = ST_OK;
                    end else begin
                        e.data = words[q][rd_ptr[q]];
                        rd_ptr[q] = 4'((int'(rd_ptr[q]) + 1) % int'(q_cap[q]));
                        q_cnt[q]--;
                        if (snd_n[q] > 0) begin
                            e.wv = 1; e.ws = 1; e.wt = pop_waiter(q, 1'b1);
                        end
                        e.status = ST_OK;
                    end
                end
            end
            ACT_PEEK: begin
                if (!q_active[q] || q_cnt[q] == 0) e.status = ST_EMPTY;
                else begin
                    e.data = words[q][rd_ptr[q]];
                    e.status = ST_OK;
                end
            end
            default: ;
        endcase
        e.cnt = q_cnt[q];
        e.space = (q_cap[q] >= q_cnt[q]) ? q_cap[q] - q_cnt[q] : '0;
        if (nwk > 0) begin
            for (int k = 0; k < nwk; k++) begin
                e.status = ST_OK; e.data = 0; e.blocked = 0; e.wv = 1;
                e.wt = wk_id[k]; e.ws = wk_side[k]; e.last = (k == nwk - 1);
                expected_results.push_back(e);
            end
        end else begin
            expected_results.push_back(e);
        end
    endtask

    // send one request, with a random gap before it unless no_idle is set; returns at the accepting edge
    task automatic send_request(input req_t r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= r.action; i_queue_index <= r.qidx; i_capacity <= r.cap;
        i_data_word <= r.word; i_task_id <= r.tid; i_task_known <= r.known;
        i_wait_mode <= r.mode;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_queue_op(r);
    endtask

    // hold off requests until every expected result has come
    task automatic drain;
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            failed = 1'b1;
        end
    endtask

    // result checker and output stall
    always @(posedge i_clk) begin
        res_t e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                $error("result with no expected result waiting");
                failed = 1'b1;
            end else begin
                e = expected_results.pop_front();
                check_field("status", e.status, o_status);
                check_field("data_out", e.data, o_data_out);
                check_field("item_count", e.cnt, o_item_count);
                check_field("free_space", e.space, o_free_space);
                check_field("caller_blocked", e.blocked, o_caller_blocked);
                check_field("woken_valid", e.wv, o_woken_valid);
                check_field("woken_task", e.wt, o_woken_task);
                check_field("woken_side", e.ws, o_woken_side);
                check_field("last", e.last, o_last);
            end
            out_stall_left = no_idle ? 0 : $urandom_range(0, 3);
        end
        if (out_stall_left > 0) begin
            i_stall <= 1'b1;
            out_stall_left--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // create and delete with bad index, bad capacity and wrong state, plus undefined action codes
    task automatic test_create_delete;
        send_request(mk(ACT_CREATE, 4'd8, 5'd4, 0, 0, 0, 0));
        send_request(mk(ACT_CREATE, 4'd15, 5'd4, 0, 0, 0, 0));
        send_request(mk(ACT_CREATE, 4'd0, 5'd0, 0, 0, 0, 0));
        send_request(mk(ACT_CREATE, 4'd0, 5'd17, 0, 0, 0, 0));
        send_request(mk(ACT_CREATE, 4'd0, 5'd31, 0, 0, 0, 0));
        send_request(mk(ACT_CREATE, 4'd0, 5'd16, 0, 0, 0, 0));
        send_request(mk(ACT_CREATE, 4'd0, 5'd2, 0, 0, 0, 0));
        send_request(mk(ACT_CREATE, 4'd7, 5'd1, 0, 0, 0, 0));
        send_request(mk(ACT_DELETE, 4'd1, 5'd0, 0, 0, 0, 0));
        send_request(mk(3'd5, 4'd0, 5'd0, 0, 0, 0, 0));
        send_request(mk(3'd7, 4'd0, 5'd0, 0, 0, 0, 0));
        drain();
    endtask

    // send, receive and peek on inactive, empty and full queues in every wait mode
    task automatic test_full_empty;
        send_request(mk(ACT_SEND, 4'd2, 0, 32'hFFFF_FFFF, 0, 1, 1));
        send_request(mk(ACT_RECEIVE, 4'd2, 0, 0, 0, 1, 1));
        send_request(mk(ACT_PEEK, 4'd2, 0, 0, 0, 0, 0));
        send_request(mk(ACT_PEEK, 4'd0, 0, 0, 0, 0, 0));
        send_request(mk(ACT_SEND, 4'd7, 0, 32'hFFFF_FFFF, 4'd15, 1, 0));
        send_request(mk(ACT_SEND, 4'd7, 0, 32'h0, 4'd1, 1, 0));
        send_request(mk(ACT_SEND, 4'd7, 0, 32'h0, 4'd1, 0, 1));
        send_request(mk(ACT_SEND, 4'd7, 0, 32'h0, 4'd2, 1, 2));
        send_request(mk(ACT_SEND, 4'd7, 0, 32'h0, 4'd3, 1, 3));
        send_request(mk(ACT_PEEK, 4'd7, 0, 0, 0, 0, 0));
        send_request(mk(ACT_RECEIVE, 4'd7, 0, 0, 0, 0, 0));
        send_request(mk(ACT_RECEIVE, 4'd7, 0, 0, 4'd4, 1, 0));
        send_request(mk(ACT_RECEIVE, 4'd7, 0, 0, 4'd5, 1, 2));
        send_request(mk(ACT_SEND, 4'd7, 0, 32'hA5A5_5A5A, 4'd6, 1, 0));
        drain();
    endtask

    // fill a receiver wait list past its size, then wake by delete
    task automatic test_wait_list;
        for (int i = 0; i <= NW; i++)
            send_request(mk(ACT_RECEIVE, 4'd0, 0, 0, 4'(i + 7), 1, 1));
        send_request(mk(ACT_DELETE, 4'd0, 0, 0, 0, 0, 0));
        send_request(mk(ACT_DELETE, 4'd7, 0, 0, 0, 0, 0));
        drain();
    endtask

    // random traffic mostly on a few valid queues
    task automatic test_random;
        req_t r;
        int pick;
        for (int n = 0; n < 134; n++) begin
            no_idle = (n >= 60 && n < 90);
            pick = $urandom_range(0, 99);
            r.qidx = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(8, 15))
                                                 : 4'($urandom_range(0, 3));
            r.cap = ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'($urandom_range(1, 4));
            r.word = $urandom;
            r.tid = 4'($urandom);
            r.known = ($urandom_range(0, 4) != 0);
            r.mode = 2'($urandom);
            if (pick < 35) r.action = ACT_SEND;
            else if (pick < 65) r.action = ACT_RECEIVE;
            else if (pick < 75) r.action = ACT_PEEK;
            else if (pick < 86) r.action = ACT_CREATE;
            else if (pick < 94) r.action = ACT_DELETE;
            else r.action = 3'($urandom_range(5, 7));
            send_request(r);
            if (n == 120) drain();
        end
        no_idle = 1'b0;
        drain();
    endtask

    initial begin
        for (int q = 0; q < NQ; q++) begin
            q_active[q] = 0; q_cap[q] = 0; q_cnt[q] = 0;
            rd_ptr[q] = 0; wr_ptr[q] = 0; snd_n[q] = 0; rcv_n[q] = 0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_create_delete();
        test_full_empty();
        test_wait_list();
        test_random();
        repeat (10) @(posedge i_clk);
        if (!failed && expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
